// ----- sv/drs_pkg.sv -----
package drs_pkg;

  // Value format and derived widths.
  localparam int VW       = 48;
  localparam int COL_W    = 8;
  localparam int ROW_W    = 12;
  localparam int GC_W     = 9;
  localparam int GR_W     = 13;
  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 4096;
  localparam int ACC_W    = 104;
  localparam int A_W      = 49;
  localparam int PROD_W   = 97;
  localparam int DIGIT_W  = 16;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 64;

  // Register indexes (byte address is 8 times the index).
  localparam logic [1:0] REG_ALPHA = 2'd0;
  localparam logic [1:0] REG_BETA  = 2'd1;
  localparam logic [1:0] REG_COLS  = 2'd2;
  localparam logic [1:0] REG_ROWS  = 2'd3;

  typedef logic signed [VW-1:0] value_t;

  // Operands of one residual evaluation.
  typedef struct packed {
    value_t s;
    value_t old;
    value_t w;
    value_t e;
    value_t n;
    value_t so;
  } rop_t;

  // One pending result with its point coordinates.
  typedef struct packed {
    rop_t              op;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              done;
  } job_t;

  // Line buffer read data for one point.
  typedef struct packed {
    value_t ra_c;
    value_t ra_p;
    value_t rt_c;
    value_t rt_m;
    value_t od_c;
  } lrd_t;

  // Round half up at bit 32, shift down and saturate to the value width.
  function automatic value_t round_sat(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] t;
    logic [ACC_W-33:0]       sh;
    value_t                  res;
    t  = x + ACC_W'(64'h8000_0000);
    sh = t[ACC_W-1:32];
    if (sh[ACC_W-33:VW-1] == '0 || sh[ACC_W-33:VW-1] == '1) begin
      res = sh[VW-1:0];
    end else if (t[ACC_W-1]) begin
      res = {1'b1, {(VW-1){1'b0}}};
    end else begin
      res = {1'b0, {(VW-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// ----- sv/drs_lines.sv -----
module drs_lines (
  input  logic                        clk,
  input  logic                        ren,
  input  logic [drs_pkg::COL_W-1:0]   raddr_c,
  input  logic [drs_pkg::COL_W-1:0]   raddr_p,
  input  logic [drs_pkg::COL_W-1:0]   raddr_m,
  input  logic                        we,
  input  logic [drs_pkg::COL_W-1:0]   waddr,
  input  drs_pkg::value_t             ra_wdata,
  input  drs_pkg::value_t             rt_wdata,
  input  drs_pkg::value_t             od_wdata,
  output drs_pkg::lrd_t               rd
);

  drs_pkg::value_t row_above_mem   [drs_pkg::MAX_COLS];
  drs_pkg::value_t row_two_mem     [drs_pkg::MAX_COLS];
  drs_pkg::value_t old_row_mem     [drs_pkg::MAX_COLS];
  drs_pkg::lrd_t   rd_r;

  // Write port shared by all three line buffers.
  always_ff @(posedge clk) begin
    if (we) begin
      row_above_mem[waddr] <= ra_wdata;
      row_two_mem[waddr]   <= rt_wdata;
      old_row_mem[waddr]   <= od_wdata;
    end
  end

  // Registered reads around the current column.
  always_ff @(posedge clk) begin
    if (ren) begin
      rd_r.ra_c <= row_above_mem[raddr_c];
      rd_r.ra_p <= row_above_mem[raddr_p];
      rd_r.rt_c <= row_two_mem[raddr_c];
      rd_r.rt_m <= row_two_mem[raddr_m];
      rd_r.od_c <= old_row_mem[raddr_c];
    end
  end

  assign rd = rd_r;

endmodule

// ----- sv/drs_resid.sv -----
module drs_resid (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  drs_pkg::rop_t        rop,
  input  logic [drs_pkg::VW-1:0] alpha,
  input  logic [drs_pkg::VW-1:0] beta,
  output logic                 done,
  output drs_pkg::value_t      result
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_RNDQ = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  localparam logic [1:0] OP_SQ    = 2'd0;
  localparam logic [1:0] OP_LIN   = 2'd1;
  localparam logic [1:0] OP_OLD   = 2'd2;
  localparam logic [1:0] OP_REACT = 2'd3;

  localparam logic [1:0] LAST_DIGIT = 2'd2;
  localparam logic [drs_pkg::A_W-1:0] FOUR_Q = 49'h4_0000_0000;

  logic [2:0]                          st_r;
  logic [1:0]                          op_r;
  logic [1:0]                          k_r;
  logic                                done_r;
  drs_pkg::value_t                     s_r;
  drs_pkg::value_t                     old_r;
  drs_pkg::value_t                     q1_r;
  drs_pkg::value_t                     result_r;
  logic signed [drs_pkg::ACC_W-1:0]    acc_r;
  logic signed [drs_pkg::ACC_W-1:0]    q_r;
  logic [drs_pkg::PROD_W-1:0]          prod_r;
  logic [drs_pkg::A_W-1:0]             a_r;
  logic [drs_pkg::VW-1:0]              b_r;
  logic                                neg_r;

  logic [drs_pkg::A_W-1:0]             a_sel;
  logic [drs_pkg::VW-1:0]              b_sel;
  logic                                neg_sel;
  logic [drs_pkg::A_W+drs_pkg::DIGIT_W-1:0] pp;
  logic [drs_pkg::PROD_W-1:0]          prod_nxt;
  logic signed [drs_pkg::ACC_W-1:0]    p_ext;
  logic signed [drs_pkg::ACC_W-1:0]    p_signed;
  logic signed [drs_pkg::ACC_W-1:0]    sq_base;
  logic signed [drs_pkg::ACC_W-1:0]    nb_base;
  logic signed [drs_pkg::VW+1:0]       nb_sum;

  function automatic logic [drs_pkg::VW-1:0] mag(input drs_pkg::value_t v);
    return v[drs_pkg::VW-1] ? drs_pkg::VW'(-v) : v;
  endfunction

  // Operand selection for the product of the current step.
  always_comb begin
    case (op_r)
      OP_SQ: begin
        a_sel   = {1'b0, mag(s_r)};
        b_sel   = mag(s_r);
        neg_sel = 1'b1;
      end
      OP_LIN: begin
        a_sel   = FOUR_Q + {1'b0, alpha};
        b_sel   = mag(s_r);
        neg_sel = ~s_r[drs_pkg::VW-1];
      end
      OP_OLD: begin
        a_sel   = {1'b0, alpha};
        b_sel   = mag(old_r);
        neg_sel = old_r[drs_pkg::VW-1];
      end
      default: begin
        a_sel   = {1'b0, beta};
        b_sel   = mag(q1_r);
        neg_sel = q1_r[drs_pkg::VW-1];
      end
    endcase
  end

  // One 16-bit digit of the multiplier per cycle, most significant first.
  assign pp       = a_r * b_r[drs_pkg::VW-1 -: drs_pkg::DIGIT_W];
  assign prod_nxt = {prod_r[drs_pkg::PROD_W-drs_pkg::DIGIT_W-1:0], {drs_pkg::DIGIT_W{1'b0}}}
                  + drs_pkg::PROD_W'(pp);

  assign p_ext    = $signed({{(drs_pkg::ACC_W-drs_pkg::PROD_W){1'b0}}, prod_r});
  assign p_signed = neg_r ? -p_ext : p_ext;
  assign sq_base  = $signed({{(drs_pkg::ACC_W-drs_pkg::VW-32){s_r[drs_pkg::VW-1]}},
                             s_r, 32'b0});
  assign nb_sum   = (drs_pkg::VW+2)'(rop.w) + (drs_pkg::VW+2)'(rop.e)
                  + (drs_pkg::VW+2)'(rop.n) + (drs_pkg::VW+2)'(rop.so);
  assign nb_base  = $signed({{(drs_pkg::ACC_W-drs_pkg::VW-34){nb_sum[drs_pkg::VW+1]}},
                             nb_sum, 32'b0});

  // Step sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      op_r   <= OP_SQ;
      k_r    <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (start) begin
            op_r <= OP_SQ;
            st_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          k_r  <= '0;
          st_r <= S_MUL;
        end
        S_MUL: begin
          k_r <= k_r + 2'd1;
          if (k_r == LAST_DIGIT) begin
            st_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (op_r == OP_SQ) begin
            st_r <= S_RNDQ;
          end else if (op_r == OP_REACT) begin
            st_r <= S_FIN;
          end else begin
            op_r <= op_r + 2'd1;
            st_r <= S_LOAD;
          end
        end
        S_RNDQ: begin
          op_r <= OP_LIN;
          st_r <= S_LOAD;
        end
        S_FIN: begin
          done_r <= 1'b1;
          st_r   <= S_IDLE;
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        if (start) begin
          s_r   <= rop.s;
          old_r <= rop.old;
          acc_r <= nb_base;
        end
      end
      S_LOAD: begin
        a_r    <= a_sel;
        b_r    <= b_sel;
        neg_r  <= neg_sel;
        prod_r <= '0;
      end
      S_MUL: begin
        prod_r <= prod_nxt;
        b_r    <= {b_r[drs_pkg::VW-drs_pkg::DIGIT_W-1:0], {drs_pkg::DIGIT_W{1'b0}}};
      end
      S_ACC: begin
        if (op_r == OP_SQ) begin
          q_r <= sq_base + p_signed;
        end else begin
          acc_r <= acc_r + p_signed;
        end
      end
      S_RNDQ: begin
        q1_r <= drs_pkg::round_sat(q_r);
      end
      S_FIN: begin
        result_r <= drs_pkg::round_sat(acc_r);
      end
      default: begin
      end
    endcase
  end

  assign done   = done_r;
  assign result = result_r;

`ifndef SYNTHESIS
  // A new evaluation is only started while the unit is free.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> st_r == S_IDLE)
    else $error("residual unit started while busy");
`endif

endmodule

// ----- sv/diffusion_reaction_stencil.sv -----
// A beat's results are computed one at a time by the shared residual unit, whose
// multiplier takes one 16-bit digit per cycle; a new beat is accepted only once every
// result of the previous beat has been loaded into the output register.
// Reset (synchronous, active low) clears counters, taps, halo edges and registers;
// line buffers need no clearing and are not swept.
module diffusion_reaction_stencil (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [drs_pkg::VW-1:0] in_s_now,
  input  logic signed [drs_pkg::VW-1:0] in_s_prev,
  input  logic signed [drs_pkg::VW-1:0] in_west_halo,
  input  logic signed [drs_pkg::VW-1:0] in_east_halo,
  input  logic signed [drs_pkg::VW-1:0] in_north_halo,
  input  logic signed [drs_pkg::VW-1:0] in_south_halo,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [drs_pkg::VW-1:0] out_residual,
  output logic [drs_pkg::COL_W-1:0]     out_col_index,
  output logic [drs_pkg::ROW_W-1:0]     out_row_index,
  output logic                          out_run_last,
  output logic                          out_tile_done,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [drs_pkg::ADDR_W-1:0]    paddr,
  input  logic [drs_pkg::DATA_W-1:0]    pwdata,
  output logic [drs_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_JOB  = 3'd2;
  localparam logic [2:0] ST_CALC = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam logic [1:0] JOB_LAST = 2'd2;

  logic [2:0]                    state_r;
  logic [drs_pkg::VW-1:0]        alpha_r;
  logic [drs_pkg::VW-1:0]        beta_r;
  logic [drs_pkg::GC_W-1:0]      grid_cols_r;
  logic [drs_pkg::GR_W-1:0]      grid_rows_r;
  logic [drs_pkg::COL_W-1:0]     col_count_r;
  logic [drs_pkg::ROW_W-1:0]     row_count_r;
  logic [drs_pkg::COL_W-1:0]     c_r;
  logic [drs_pkg::ROW_W-1:0]     r_r;
  drs_pkg::value_t               s_in_r;
  drs_pkg::value_t               o_in_r;
  drs_pkg::value_t               wh_r;
  drs_pkg::value_t               eh_r;
  drs_pkg::value_t               nh_r;
  drs_pkg::value_t               sh_r;
  drs_pkg::value_t               edge_w_r;
  drs_pkg::value_t               edge_e_r;
  drs_pkg::value_t               tap_r [5];
  drs_pkg::job_t                 job_r [3];
  logic [2:0]                    job_vld_r;
  logic [1:0]                    jidx_r;
  logic                          out_valid_r;
  drs_pkg::value_t               out_res_r;
  logic [drs_pkg::COL_W-1:0]     out_col_r;
  logic [drs_pkg::ROW_W-1:0]     out_row_r;
  logic                          out_last_r;
  logic                          out_done_r;

  logic                          in_fire;
  logic                          cfg_we;
  logic [1:0]                    cfg_idx;
  logic [drs_pkg::GC_W-1:0]      cols_wr;
  logic [drs_pkg::GR_W-1:0]      rows_wr;
  logic                          wrap;
  logic [drs_pkg::COL_W-1:0]     c_cur;
  logic [drs_pkg::ROW_W-1:0]     r_cur;
  logic [drs_pkg::COL_W-1:0]     lc;
  logic [drs_pkg::ROW_W-1:0]     lr;
  logic                          col_first;
  logic                          col_last;
  logic                          row_last;
  drs_pkg::value_t               w_last;
  drs_pkg::lrd_t                 lrd;
  drs_pkg::job_t                 job_a;
  drs_pkg::job_t                 job_b;
  drs_pkg::job_t                 job_c;
  drs_pkg::job_t                 job_cur;
  logic                          later_vld;
  logic                          out_load;
  logic                          res_start;
  logic                          res_done;
  drs_pkg::value_t               res_value;

  assign in_fire  = in_valid & in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign pready   = 1'b1;
  assign cfg_we   = psel & penable & pwrite;
  assign cfg_idx  = paddr[4:3];

  // Size writes are clamped to the supported range.
  always_comb begin
    cols_wr = pwdata[drs_pkg::GC_W-1:0];
    if (cols_wr < drs_pkg::GC_W'(2)) begin
      cols_wr = drs_pkg::GC_W'(2);
    end else if (cols_wr > drs_pkg::GC_W'(drs_pkg::MAX_COLS)) begin
      cols_wr = drs_pkg::GC_W'(drs_pkg::MAX_COLS);
    end
    rows_wr = pwdata[drs_pkg::GR_W-1:0];
    if (rows_wr < drs_pkg::GR_W'(2)) begin
      rows_wr = drs_pkg::GR_W'(2);
    end else if (rows_wr > drs_pkg::GR_W'(drs_pkg::MAX_ROWS)) begin
      rows_wr = drs_pkg::GR_W'(drs_pkg::MAX_ROWS);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r     <= '0;
      beta_r      <= '0;
      grid_cols_r <= drs_pkg::GC_W'(2);
      grid_rows_r <= drs_pkg::GR_W'(2);
    end else if (cfg_we) begin
      case (cfg_idx)
        drs_pkg::REG_ALPHA: alpha_r     <= pwdata[drs_pkg::VW-1:0];
        drs_pkg::REG_BETA:  beta_r      <= pwdata[drs_pkg::VW-1:0];
        drs_pkg::REG_COLS:  grid_cols_r <= cols_wr;
        default:            grid_rows_r <= rows_wr;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      drs_pkg::REG_ALPHA: prdata = drs_pkg::DATA_W'(alpha_r);
      drs_pkg::REG_BETA:  prdata = drs_pkg::DATA_W'(beta_r);
      drs_pkg::REG_COLS:  prdata = drs_pkg::DATA_W'(grid_cols_r);
      default:            prdata = drs_pkg::DATA_W'(grid_rows_r);
    endcase
  end

  // Position of the arriving point; a counter past the size restarts the tile.
  assign wrap  = ({1'b0, col_count_r} >= grid_cols_r) || ({1'b0, row_count_r} >= grid_rows_r);
  assign c_cur = wrap ? '0 : col_count_r;
  assign r_cur = wrap ? '0 : row_count_r;
  assign lc    = drs_pkg::COL_W'(grid_cols_r - drs_pkg::GC_W'(1));
  assign lr    = drs_pkg::ROW_W'(grid_rows_r - drs_pkg::GR_W'(1));

  assign col_first = (c_r == '0);
  assign col_last  = (c_r == lc);
  assign row_last  = (r_r == lr);
  assign w_last    = col_first ? wh_r : tap_r[0];

  drs_lines u_lines (
    .clk      (clk),
    .ren      (in_fire),
    .raddr_c  (c_cur),
    .raddr_p  (c_cur + drs_pkg::COL_W'(1)),
    .raddr_m  (c_cur - drs_pkg::COL_W'(1)),
    .we       (state_r == ST_RD),
    .waddr    (c_r),
    .ra_wdata (s_in_r),
    .rt_wdata ((r_r == '0) ? sh_r : lrd.ra_c),
    .od_wdata (o_in_r),
    .rd       (lrd)
  );

  // The three results a point can complete.
  always_comb begin
    job_a.op.s   = lrd.ra_c;
    job_a.op.old = lrd.od_c;
    job_a.op.w   = col_first ? edge_w_r : lrd.rt_m;
    job_a.op.e   = col_last ? edge_e_r : lrd.ra_p;
    job_a.op.n   = s_in_r;
    job_a.op.so  = lrd.rt_c;
    job_a.col    = c_r;
    job_a.row    = r_r - drs_pkg::ROW_W'(1);
    job_a.done   = 1'b0;

    job_b.op.s   = tap_r[0];
    job_b.op.old = tap_r[1];
    job_b.op.w   = tap_r[2];
    job_b.op.e   = s_in_r;
    job_b.op.n   = tap_r[4];
    job_b.op.so  = tap_r[3];
    job_b.col    = c_r - drs_pkg::COL_W'(1);
    job_b.row    = r_r;
    job_b.done   = 1'b0;

    job_c.op.s   = s_in_r;
    job_c.op.old = o_in_r;
    job_c.op.w   = w_last;
    job_c.op.e   = eh_r;
    job_c.op.n   = nh_r;
    job_c.op.so  = lrd.ra_c;
    job_c.col    = c_r;
    job_c.row    = r_r;
    job_c.done   = 1'b1;
  end

  assign job_cur   = job_r[jidx_r];
  assign later_vld = (jidx_r == 2'd0) ? (job_vld_r[1] | job_vld_r[2]) :
                     (jidx_r == 2'd1) ? job_vld_r[2] : 1'b0;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign res_start = (state_r == ST_JOB) && job_vld_r[jidx_r];

  drs_resid u_resid (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (res_start),
    .rop    (job_cur.op),
    .alpha  (alpha_r),
    .beta   (beta_r),
    .done   (res_done),
    .result (res_value)
  );

  // Control: state, counters, taps and halo edges.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_count_r <= '0;
      row_count_r <= '0;
      job_vld_r   <= '0;
      jidx_r      <= '0;
      out_valid_r <= 1'b0;
      edge_w_r    <= '0;
      edge_e_r    <= '0;
      for (int i = 0; i < 5; i++) begin
        tap_r[i] <= '0;
      end
    end else begin
      // A result beat stays until taken; a new one is loaded in its place.
      out_valid_r <= out_load || (out_valid_r && !out_ready);
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (c_cur == lc) begin
              col_count_r <= '0;
              row_count_r <= (r_cur == lr) ? '0 : r_cur + drs_pkg::ROW_W'(1);
            end else begin
              col_count_r <= c_cur + drs_pkg::COL_W'(1);
              row_count_r <= r_cur;
            end
            state_r <= ST_RD;
          end
        end
        ST_RD: begin
          job_vld_r[0] <= (r_r != '0);
          job_vld_r[1] <= row_last && !col_first;
          job_vld_r[2] <= row_last && col_last;
          jidx_r       <= '0;
          if (row_last) begin
            tap_r[0] <= s_in_r;
            tap_r[1] <= o_in_r;
            tap_r[2] <= w_last;
            tap_r[3] <= lrd.ra_c;
            tap_r[4] <= nh_r;
          end
          if (col_first) begin
            edge_w_r <= wh_r;
          end
          if (col_last) begin
            edge_e_r <= eh_r;
          end
          state_r <= ((r_r != '0) || row_last) ? ST_JOB : ST_IDLE;
        end
        ST_JOB: begin
          if (job_vld_r[jidx_r]) begin
            state_r <= ST_CALC;
          end else if (jidx_r == JOB_LAST) begin
            state_r <= ST_IDLE;
          end else begin
            jidx_r <= jidx_r + 2'd1;
          end
        end
        ST_CALC: begin
          if (res_done) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            if (!later_vld) begin
              state_r <= ST_IDLE;
            end else begin
              jidx_r  <= jidx_r + 2'd1;
              state_r <= ST_JOB;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Beat payload and point registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      c_r    <= c_cur;
      r_r    <= r_cur;
      s_in_r <= in_s_now;
      o_in_r <= in_s_prev;
      wh_r   <= in_west_halo;
      eh_r   <= in_east_halo;
      nh_r   <= in_north_halo;
      sh_r   <= in_south_halo;
    end
    if (state_r == ST_RD) begin
      job_r[0] <= job_a;
      job_r[1] <= job_b;
      job_r[2] <= job_c;
    end
    if (out_load) begin
      out_res_r  <= res_value;
      out_col_r  <= job_cur.col;
      out_row_r  <= job_cur.row;
      out_last_r <= !later_vld;
      out_done_r <= job_cur.done;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_residual  = out_res_r;
  assign out_col_index = out_col_r;
  assign out_row_index = out_row_r;
  assign out_run_last  = out_last_r;
  assign out_tile_done = out_done_r;

`ifndef SYNTHESIS
  // An accepted beat is always followed by the line buffer read cycle.
  a_fire_rd: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_RD)
    else $error("accepted beat not followed by read cycle");

  // The residual unit only finishes while a job waits for it.
  a_done_calc: assert property (@(posedge clk) disable iff (!rst_n)
    res_done |-> state_r == ST_CALC)
    else $error("residual finished outside calculation state");

  // A new result beat is only loaded from the output state.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result beat appeared without output state");

  // A tile-done result is always the last of its beat.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> out_last_r)
    else $error("tile done result not marked last");
`endif

endmodule
